[hw/rtl/bfe_pkg.sv]
package bfe_pkg;

	// Field and register widths
	localparam int COLOR_W = 24;
	localparam int COUNT_W = 15;
	localparam int COORD_W = 7;
	localparam int CMD_W   = 2;

	// Register reset values: red boundary, green fill
	localparam logic [COLOR_W-1:0] BOUNDARY_RESET = 24'hFF0000;
	localparam logic [COLOR_W-1:0] FILL_RESET     = 24'h00FF00;

	// Register indexes, taken from the word address
	localparam logic REG_BOUNDARY = 1'b0;
	localparam logic REG_FILL     = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_FILL  = 2'd2
	} cmd_t;

	// Neighbor visit order for one popped pixel
	typedef enum logic [1:0] {
		NBR_RIGHT = 2'd0,
		NBR_LEFT  = 2'd1,
		NBR_DOWN  = 2'd2,
		NBR_UP    = 2'd3
	} nbr_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_POP,
		ST_POP_WAIT,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

[hw/rtl/bfe_ram.sv]
module bfe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with a registered output
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/boundary_fill_engine.sv]
// Pixel store of GRID_WIDTH x GRID_HEIGHT packed RGB colors with a
// four-connected boundary fill. After reset the store is swept to black, one
// pixel per cycle; no word is accepted during that sweep, but register
// writes are. A fill is paced by the single frame memory read port: each
// recolored pixel is popped from the stack memory (one read with a
// registered output) unless its probe completes in the pop state, and its
// up to four neighbors are probed one per cycle, a probe's compare and
// write-back overlapping the next probe.
// Neighbors off the grid count as boundary. One command is in work at a time;
// the next word is taken while the previous result still waits on the
// output.
module boundary_fill_engine #(
	parameter int GRID_WIDTH  = 128,
	parameter int GRID_HEIGHT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Command stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // x[6:0], y[13:7], pixel_in[37:14], zero
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // pixel_out[23:0], filled_count[38:24], zero
);

	import bfe_pkg::*;

	localparam int PIXELS = GRID_WIDTH * GRID_HEIGHT;
	localparam int IW     = $clog2(PIXELS);
	localparam int TW     = $clog2(PIXELS + 1);
	localparam int XW     = $clog2(GRID_WIDTH);
	localparam int YW     = $clog2(GRID_HEIGHT);
	localparam int SW     = XW + YW;

	state_t state_q, state_d;

	// Registers
	logic [COLOR_W-1:0] boundary_q;
	logic [COLOR_W-1:0] fill_q;

	// Latched command
	cmd_t               cmd_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [COLOR_W-1:0] pix_q;

	// Fill state
	logic [IW-1:0]      clr_q;
	logic [TW-1:0]      top_q;
	logic [TW-1:0]      count_q;
	logic [COLOR_W-1:0] res_pixel_q;
	logic [XW-1:0]      cur_x_q;
	logic [YW-1:0]      cur_y_q;
	logic [IW-1:0]      cur_idx_q;
	nbr_t               nbr_q;

	// Probe in flight: frame read issued last cycle
	logic               probe_valid_s1;
	logic [XW-1:0]      probe_x_s1;
	logic [YW-1:0]      probe_y_s1;
	logic [IW-1:0]      probe_idx_s1;

	// Output register
	logic               out_valid_q;
	logic [COLOR_W-1:0] out_pixel_q;
	logic [COUNT_W-1:0] out_count_q;

	// Memory ports
	logic               frm_we, frm_re;
	logic [IW-1:0]      frm_waddr, frm_raddr;
	logic [COLOR_W-1:0] frm_wdata, frm_rdata;
	logic               stk_we, stk_re;
	logic [IW-1:0]      stk_waddr, stk_raddr;
	logic [SW-1:0]      stk_wdata, stk_rdata;

	// Combinational helpers
	logic               on_grid;
	logic [IW-1:0]      exec_idx;
	logic [XW-1:0]      exec_x;
	logic [YW-1:0]      exec_y;
	logic               probe_hit;
	logic               probe_issue;
	logic               nbr_ok;
	logic [XW-1:0]      nbr_x;
	logic [YW-1:0]      nbr_y;
	logic [IW-1:0]      nbr_idx;
	logic [XW-1:0]      pop_x;
	logic [YW-1:0]      pop_y;
	logic [IW-1:0]      pop_idx;
	logic               out_load;
	logic               in_accept;
	logic               cfg_write;

	bfe_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PIXELS)
	) u_frame (
		.clk    (clk),
		.wr_en  (frm_we),
		.wr_addr(frm_waddr),
		.wr_data(frm_wdata),
		.rd_en  (frm_re),
		.rd_addr(frm_raddr),
		.rd_data(frm_rdata)
	);

	bfe_ram #(
		.WIDTH(SW),
		.DEPTH(PIXELS)
	) u_stack (
		.clk    (clk),
		.wr_en  (stk_we),
		.wr_addr(stk_waddr),
		.wr_data(stk_wdata),
		.rd_en  (stk_re),
		.rd_addr(stk_raddr),
		.rd_data(stk_rdata)
	);

	// Register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_BOUNDARY: prdata = {8'd0, boundary_q};
			REG_FILL:     prdata = {8'd0, fill_q};
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boundary_q <= BOUNDARY_RESET;
			fill_q     <= FILL_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_BOUNDARY: boundary_q <= pwdata[COLOR_W-1:0];
				REG_FILL:     fill_q     <= pwdata[COLOR_W-1:0];
				default:      ;
			endcase
		end
	end

	// Stream handshakes
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_count_q, out_pixel_q};

	// Decode the latched coordinate
	assign on_grid  = (32'(x_q) < 32'(GRID_WIDTH)) && (32'(y_q) < 32'(GRID_HEIGHT));
	assign exec_idx = IW'(32'(y_q) * 32'(GRID_WIDTH) + 32'(x_q));
	assign exec_x   = XW'(32'(x_q));
	assign exec_y   = YW'(32'(y_q));

	// Popped stack entry back to an address
	assign pop_x   = stk_rdata[XW-1:0];
	assign pop_y   = stk_rdata[SW-1:XW];
	assign pop_idx = IW'(32'(pop_y) * 32'(GRID_WIDTH) + 32'(pop_x));

	// Probe result: recolor and push if neither boundary nor fill color
	assign probe_hit = probe_valid_s1 && (frm_rdata != boundary_q) && (frm_rdata != fill_q);

	// Current neighbor and its bounds
	always_comb begin
		nbr_ok  = 1'b0;
		nbr_x   = cur_x_q;
		nbr_y   = cur_y_q;
		nbr_idx = cur_idx_q;
		case (nbr_q)
			NBR_RIGHT: begin
				nbr_ok  = (cur_x_q != XW'(GRID_WIDTH - 1));
				nbr_x   = cur_x_q + XW'(1);
				nbr_idx = cur_idx_q + IW'(1);
			end
			NBR_LEFT: begin
				nbr_ok  = (cur_x_q != '0);
				nbr_x   = cur_x_q - XW'(1);
				nbr_idx = cur_idx_q - IW'(1);
			end
			NBR_DOWN: begin
				nbr_ok  = (cur_y_q != YW'(GRID_HEIGHT - 1));
				nbr_y   = cur_y_q + YW'(1);
				nbr_idx = cur_idx_q + IW'(GRID_WIDTH);
			end
			NBR_UP: begin
				nbr_ok  = (cur_y_q != '0);
				nbr_y   = cur_y_q - YW'(1);
				nbr_idx = cur_idx_q - IW'(GRID_WIDTH);
			end
			default: ;
		endcase
	end

	// Next state and memory control
	always_comb begin
		state_d     = state_q;
		frm_we      = 1'b0;
		frm_waddr   = probe_idx_s1;
		frm_wdata   = fill_q;
		frm_re      = 1'b0;
		frm_raddr   = nbr_idx;
		stk_we      = probe_hit;
		stk_waddr   = top_q[IW-1:0];
		stk_wdata   = {probe_y_s1, probe_x_s1};
		stk_re      = 1'b0;
		stk_raddr   = top_q[IW-1:0] - IW'(1);
		probe_issue = 1'b0;
		out_load    = 1'b0;

		// Recolor a probed pixel that may be filled
		if (probe_hit) begin
			frm_we = 1'b1;
		end

		unique case (state_q)
			ST_CLEAR: begin
				frm_we    = 1'b1;
				frm_waddr = clr_q;
				frm_wdata = '0;
				if (clr_q == IW'(PIXELS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				frm_raddr = exec_idx;
				frm_waddr = exec_idx;
				frm_wdata = pix_q;
				case (cmd_q)
					CMD_WRITE: begin
						frm_we  = on_grid;
						state_d = ST_DONE;
					end
					CMD_READ: begin
						frm_re  = on_grid;
						state_d = ST_READ;
					end
					CMD_FILL: begin
						frm_re      = on_grid;
						probe_issue = on_grid;
						state_d     = on_grid ? ST_POP : ST_DONE;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_POP: begin
				// A pixel pushed this cycle is popped at once
				if (probe_hit) begin
					state_d = ST_SCAN;
				end else if (top_q != '0) begin
					stk_re  = 1'b1;
					state_d = ST_POP_WAIT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_POP_WAIT: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				frm_re      = nbr_ok;
				probe_issue = nbr_ok;
				if (nbr_q == NBR_UP) begin
					state_d = ST_POP;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters and probe valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q          <= '0;
			top_q          <= '0;
			probe_valid_s1 <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			probe_valid_s1 <= probe_issue;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			// Stack pointer: clear at execute, pop in the pop state unless a hit arrives, push on hit elsewhere
			if (state_q == ST_EXEC) begin
				top_q <= '0;
			end else if (state_q == ST_POP) begin
				if (!probe_hit && top_q != '0) begin
					top_q <= top_q - TW'(1);
				end
			end else if (probe_hit) begin
				top_q <= top_q + TW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q <= cmd_t'(s_axis_tuser);
			x_q   <= s_axis_tdata[6:0];
			y_q   <= s_axis_tdata[13:7];
			pix_q <= s_axis_tdata[37:14];
		end
		if (probe_issue) begin
			probe_x_s1   <= (state_q == ST_EXEC) ? exec_x : nbr_x;
			probe_y_s1   <= (state_q == ST_EXEC) ? exec_y : nbr_y;
			probe_idx_s1 <= (state_q == ST_EXEC) ? exec_idx : nbr_idx;
		end
		if (state_q == ST_EXEC) begin
			count_q     <= '0;
			res_pixel_q <= '0;
		end else if (probe_hit) begin
			count_q <= count_q + TW'(1);
		end
		// An off-grid read keeps the zero loaded at execute
		if (state_q == ST_READ && on_grid) begin
			res_pixel_q <= frm_rdata;
		end
		// Load the pixel whose neighbors are scanned next
		if (state_q == ST_POP && probe_hit) begin
			cur_x_q   <= probe_x_s1;
			cur_y_q   <= probe_y_s1;
			cur_idx_q <= probe_idx_s1;
			nbr_q     <= NBR_RIGHT;
		end else if (state_q == ST_POP_WAIT) begin
			cur_x_q   <= pop_x;
			cur_y_q   <= pop_y;
			cur_idx_q <= pop_idx;
			nbr_q     <= NBR_RIGHT;
		end else if (state_q == ST_SCAN) begin
			nbr_q <= nbr_t'(nbr_q + 2'd1);
		end
		if (out_load) begin
			out_pixel_q <= res_pixel_q;
			out_count_q <= COUNT_W'(count_q);
		end
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	import bfe_pkg::*;

	localparam int GRID_W      = 128;
	localparam int GRID_H      = 128;
	localparam int PIXELS      = GRID_W * GRID_H;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int PHASE_WORDS = 24;

	// Command code left unused by the block
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	localparam logic [COLOR_W-1:0] BLACK = 24'h000000;
	localparam logic [COLOR_W-1:0] WHITE = 24'hFFFFFF;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel;
		logic [COUNT_W-1:0] count;
	} result_t;

	typedef struct packed {
		logic [CMD_W-1:0]   op;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [COLOR_W-1:0] color;
		logic               known;
		logic [COLOR_W-1:0] want_pixel;
		logic [COUNT_W-1:0] want_count;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // x[6:0], y[13:7], pixel_in[37:14], zero
	logic [1:0]  s_axis_tuser = '0;  // cmd[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;       // pixel_out[23:0], filled_count[38:24], zero

	// Shadow of the frame store and the color registers
	logic [COLOR_W-1:0] shadow_px [0:PIXELS-1];
	logic [COLOR_W-1:0] shadow_boundary;
	logic [COLOR_W-1:0] shadow_fill;
	logic [13:0]        fill_pending [$];

	result_t awaited [$];

	int errors         = 0;
	int words_sent     = 0;
	int fills_seen     = 0;
	int pixels_painted = 0;
	int settings_used  = 1;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// Directed steps: fresh store, field extremes, every command, seed corner cases
	step_t directed_steps [22] = '{
		'{CMD_READ,  7'd0,   7'd0,   BLACK,          1'b1, BLACK,          15'd0},
		'{CMD_READ,  7'd127, 7'd127, BLACK,          1'b1, BLACK,          15'd0},
		'{CMD_WRITE, 7'd0,   7'd0,   WHITE,          1'b1, BLACK,          15'd0},
		'{CMD_READ,  7'd0,   7'd0,   BLACK,          1'b1, WHITE,          15'd0},
		'{CMD_WRITE, 7'd127, 7'd127, BLACK,          1'b1, BLACK,          15'd0},
		'{CMD_SPARE, 7'd127, 7'd127, WHITE,          1'b1, BLACK,          15'd0},
		'{CMD_WRITE, 7'd127, 7'd0,   BOUNDARY_RESET, 1'b1, BLACK,          15'd0},
		// seed sits on the boundary color
		'{CMD_FILL,  7'd127, 7'd0,   BLACK,          1'b1, BLACK,          15'd0},
		'{CMD_READ,  7'd127, 7'd0,   BLACK,          1'b1, BOUNDARY_RESET, 15'd0},
		// box in the bottom-left corner pixel; the grid edge closes the rest
		'{CMD_WRITE, 7'd1,   7'd127, BOUNDARY_RESET, 1'b1, BLACK,          15'd0},
		'{CMD_WRITE, 7'd0,   7'd126, BOUNDARY_RESET, 1'b1, BLACK,          15'd0},
		'{CMD_FILL,  7'd0,   7'd127, BLACK,          1'b1, BLACK,          15'd1},
		'{CMD_READ,  7'd0,   7'd127, BLACK,          1'b1, FILL_RESET,     15'd0},
		// seed already holds the fill color
		'{CMD_FILL,  7'd0,   7'd127, BLACK,          1'b1, BLACK,          15'd0},
		// flood the open area
		'{CMD_FILL,  7'd64,  7'd64,  BLACK,          1'b0, BLACK,          15'd0},
		'{CMD_READ,  7'd64,  7'd64,  BLACK,          1'b0, BLACK,          15'd0},
		'{CMD_READ,  7'd0,   7'd0,   BLACK,          1'b0, BLACK,          15'd0},
		'{CMD_READ,  7'd127, 7'd127, BLACK,          1'b0, BLACK,          15'd0},
		'{CMD_WRITE, 7'd42,  7'd85,  24'hAAAAAA,     1'b1, BLACK,          15'd0},
		'{CMD_READ,  7'd42,  7'd85,  BLACK,          1'b1, 24'hAAAAAA,     15'd0},
		'{CMD_WRITE, 7'd85,  7'd42,  24'h555555,     1'b1, BLACK,          15'd0},
		'{CMD_READ,  7'd85,  7'd42,  BLACK,          1'b1, 24'h555555,     15'd0}
	};

	boundary_fill_engine #(
		.GRID_WIDTH  (GRID_W),
		.GRID_HEIGHT (GRID_H)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Recolor and stack a pixel unless it holds the boundary or fill color
	function automatic logic [COUNT_W-1:0] claim_pixel(logic [13:0] idx);
		if (shadow_px[idx] == shadow_boundary || shadow_px[idx] == shadow_fill)
			return 15'd0;
		shadow_px[idx] = shadow_fill;
		fill_pending.push_back(idx);
		return 15'd1;
	endfunction

	// Four-connected flood from a seed; off-grid neighbors are skipped
	function automatic logic [COUNT_W-1:0] flood_from(logic [6:0] sx, logic [6:0] sy);
		logic [COUNT_W-1:0] n;
		logic [13:0]        idx;
		fill_pending.delete();
		n = claim_pixel({sy, sx});
		while (fill_pending.size() != 0) begin
			idx = fill_pending.pop_back();
			if (idx[6:0] != 7'(GRID_W - 1))
				n += claim_pixel(idx + 14'd1);
			if (idx[6:0] != 7'd0)
				n += claim_pixel(idx - 14'd1);
			if (idx[13:7] != 7'(GRID_H - 1))
				n += claim_pixel(idx + 14'(GRID_W));
			if (idx[13:7] != 7'd0)
				n += claim_pixel(idx - 14'(GRID_W));
		end
		return n;
	endfunction

	// Apply one command to the shadow store and return the result it owes
	function automatic result_t predict_command(logic [CMD_W-1:0] op, logic [6:0] col,
			logic [6:0] row, logic [COLOR_W-1:0] color);
		result_t r;
		r = '0;
		case (op)
			CMD_WRITE: shadow_px[{row, col}] = color;
			CMD_READ:  r.pixel = shadow_px[{row, col}];
			CMD_FILL: begin
				r.count = flood_from(col, row);
				fills_seen++;
				pixels_painted += int'(r.count);
			end
			default: ;
		endcase
		return r;
	endfunction

	// Offer one command word, wait for it to be taken, log what it owes
	task automatic issue_command(input logic [CMD_W-1:0] op, input logic [6:0] col,
			input logic [6:0] row, input logic [COLOR_W-1:0] color,
			input logic known, input result_t typed);
		result_t guess;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {2'b00, color, row, col};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		guess = predict_command(op, col, row, color);
		awaited.push_back(known ? typed : guess);
		words_sent++;
	endtask

	// Hold the sender off until every owed result is back
	task automatic drain_replies();
		if (awaited.size() != 0) begin
			s_axis_tvalid <= 1'b0;
			while (awaited.size() != 0)
				@(posedge clk);
		end
	endtask

	// One APB transfer; psel stays high so transfers can run back to back
	task automatic apb_transfer(input logic is_write, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
	endtask

	// Write both color registers, then read them back
	task automatic set_colors(input logic [COLOR_W-1:0] boundary, input logic [COLOR_W-1:0] fill);
		logic [31:0]        got;
		logic [2:0]         reg_addr [2];
		logic [COLOR_W-1:0] reg_val [2];
		reg_addr[0] = {REG_BOUNDARY, 2'b00};
		reg_addr[1] = {REG_FILL, 2'b00};
		reg_val[0]  = boundary;
		reg_val[1]  = fill;
		for (int r = 0; r < 2; r++)
			apb_transfer(1'b1, reg_addr[r], {8'h00, reg_val[r]}, got);
		for (int r = 0; r < 2; r++) begin
			apb_transfer(1'b0, reg_addr[r], 32'h0, got);
			if (got[COLOR_W-1:0] != reg_val[r]) begin
				$display("%0t: register at %0d expected %h got %h", $time, reg_addr[r],
					reg_val[r], got[COLOR_W-1:0]);
				errors++;
			end
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		shadow_boundary = boundary;
		shadow_fill     = fill;
		settings_used++;
	endtask

	// Half the time one shared ink so patches form connected islands
	function automatic logic [COLOR_W-1:0] pick_ink(logic [COLOR_W-1:0] ink);
		case ($urandom_range(9))
			0:       return shadow_boundary;
			1:       return shadow_fill;
			2:       return BLACK;
			3:       return WHITE;
			4:       return 24'($urandom());
			default: return ink;
		endcase
	endfunction

	// Paint a few pixels in a 4x4 patch, fill from inside it, read some back
	task automatic paint_patch();
		logic [6:0]         bx;
		logic [6:0]         by;
		logic [COLOR_W-1:0] ink;
		int                 strokes;
		int                 probes;
		bx      = 7'($urandom_range(GRID_W - 4));
		by      = 7'($urandom_range(GRID_H - 4));
		ink     = 24'($urandom());
		strokes = $urandom_range(3, 8);
		probes  = $urandom_range(1, 3);
		repeat (strokes)
			issue_command(CMD_WRITE, bx + 7'($urandom_range(3)), by + 7'($urandom_range(3)),
				pick_ink(ink), 1'b0, '0);
		issue_command(CMD_FILL, bx + 7'($urandom_range(3)), by + 7'($urandom_range(3)),
			24'($urandom()), 1'b0, '0);
		repeat (probes)
			issue_command(CMD_READ, bx + 7'($urandom_range(3)), by + 7'($urandom_range(3)),
				24'($urandom()), 1'b0, '0);
	endtask

	// Receiver back-pressure
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Compare each result word with the oldest owed result
	always @(posedge clk) begin : take_result
		result_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited.size() == 0) begin
				$display("%0t: result %h arrived with none expected", $time, m_axis_tdata);
				errors++;
			end else begin
				due = awaited.pop_front();
				if (m_axis_tdata[23:0] != due.pixel) begin
					$display("%0t: pixel_out expected %h got %h", $time, due.pixel,
						m_axis_tdata[23:0]);
					errors++;
				end
				if (m_axis_tdata[38:24] != due.count) begin
					$display("%0t: filled_count expected %0d got %0d", $time, due.count,
						m_axis_tdata[38:24]);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run stopped after %0d cycles", $time, cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [COLOR_W-1:0] phase_boundary [3];
		logic [COLOR_W-1:0] phase_fill [3];
		int                 target;
		bit                 held;
		// The first setting keeps the sea of the previous fill as boundary,
		// the second floods it with boundary equal to fill, the last is the
		// opposite extreme pair
		phase_boundary[0] = FILL_RESET;
		phase_fill[0]     = BLACK;
		phase_boundary[1] = WHITE;
		phase_fill[1]     = WHITE;
		phase_boundary[2] = BLACK;
		phase_fill[2]     = WHITE;
		held = 1'b0;
		foreach (shadow_px[i])
			shadow_px[i] = BLACK;
		shadow_boundary = BOUNDARY_RESET;
		shadow_fill     = FILL_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		foreach (directed_steps[i])
			issue_command(directed_steps[i].op, directed_steps[i].col, directed_steps[i].row,
				directed_steps[i].color, directed_steps[i].known,
				{directed_steps[i].want_pixel, directed_steps[i].want_count});

		// Random patches and stray commands under each color setting
		for (int p = 0; p < 3; p++) begin
			drain_replies();
			set_colors(phase_boundary[p], phase_fill[p]);
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				case ((words_sent / 12) % 4)
					0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
					default: begin send_idle_pct = 20; recv_stall_pct = 20; end
				endcase
				if (!held && words_sent >= 70) begin
					held = 1'b1;
					drain_replies();
				end
				if ($urandom_range(4) == 0)
					issue_command(2'($urandom_range(3)), 7'($urandom()), 7'($urandom()),
						24'($urandom()), 1'b0, '0);
				else
					paint_patch();
			end
		end

		drain_replies();
		repeat (60) @(posedge clk);

		$display("Sent %0d commands over %0d color settings; %0d fills recolored %0d pixels.",
			words_sent, settings_used, fills_seen, pixels_painted);
		$display("Traffic mixed free-running, sender gaps, result stalls and both together.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
